/* hw/rtl/brd_pkg.sv */
`default_nettype none

package brd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned HwW   = 4;

  localparam logic [PosW-1:0] PosMax = 8'hff;
  localparam logic [3:0] LowNibble    = 4'hf;
  localparam logic [3:0] TypeAudio    = 4'hb;
  localparam logic [3:0] TypeError    = 4'hf;
  localparam logic [3:0] TypeFrontend = 4'hc;

  typedef enum logic [2:0] {
    StAudio    = 3'd0,
    StError    = 3'd1,
    StFrontend = 3'd2,
    StUnknown  = 3'd3,
    StTrunc    = 3'd4
  } status_e;

  // one input item
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic             audio_valid;
    logic [ByteW-1:0] audio_byte;
    logic             summary_valid;
    logic [3:0]       msg_type;
    logic [3:0]       type_flags;
    logic [3:0]       serialization;
    logic [3:0]       compression;
    logic [WordW-1:0] sequence_res;
    logic [WordW-1:0] size_word;
    logic [WordW-1:0] error_code;
    logic             stream_done;
    status_e          status;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/brd_in_stage.sv */
`default_nettype none

module brd_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire brd_pkg::item_t in_item_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output brd_pkg::item_t     item_o
);
  import brd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/brd_parse.sv */
`default_nettype none

module brd_parse (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire brd_pkg::item_t item_i,
  input  wire logic           fire_i,
  output logic                produce_o,
  output brd_pkg::res_t       res_o
);
  import brd_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [HwW-1:0]   hw_q, hw_d;
  logic [3:0]       type_q, type_d;
  logic [3:0]       flags_q, flags_d;
  logic [ByteW-1:0] sc_q, sc_d;
  logic [WordW-1:0] first_q, first_d;
  logic [WordW-1:0] second_q, second_d;

  logic [ByteW-1:0] b;
  logic [5:0]       start;
  logic [PosW-1:0]  q;
  logic             in_payload;
  logic             audio_words;
  logic             words;
  logic             audio_v;
  logic [8:0]       count;
  logic [6:0]       need;

  assign b = item_i.data_byte;

  always_comb begin
    hw_d     = hw_q;
    type_d   = type_q;
    flags_d  = flags_q;
    sc_d     = sc_q;
    first_d  = first_q;
    second_d = second_q;
    audio_v  = 1'b0;

    if (pos_q == '0) begin
      // header size zero counts as one word
      hw_d     = (b[3:0] == 4'd0) ? 4'd1 : (b[3:0] & LowNibble);
      type_d   = '0;
      flags_d  = '0;
      sc_d     = '0;
      first_d  = '0;
      second_d = '0;
    end else if (pos_q == 8'd1) begin
      type_d  = b[7:4];
      flags_d = b[3:0] & LowNibble;
    end else if (pos_q == 8'd2) begin
      sc_d = b;
    end

    start       = {hw_d, 2'b00};
    in_payload  = (pos_q >= 8'd2) && (pos_q >= {2'b00, start});
    q           = pos_q - {2'b00, start};
    audio_words = (type_d == TypeAudio) && (flags_d != 4'd0);
    words       = audio_words || (type_d == TypeError) || (type_d == TypeFrontend);

    if (in_payload) begin
      if (words && (q < 8'd4)) begin
        first_d = {first_d[WordW-ByteW-1:0], b};
      end else if (words && (q < 8'd8) && (type_d != TypeFrontend)) begin
        second_d = {second_d[WordW-ByteW-1:0], b};
      end else if (audio_words && (q >= 8'd8)) begin
        audio_v = 1'b1;
      end
    end

    // bytes the type needs before the summary can be trusted
    if (audio_words || (type_d == TypeError)) begin
      need = {1'b0, start} + 7'd8;
    end else if (type_d == TypeFrontend) begin
      need = {1'b0, start} + 7'd4;
    end else begin
      need = {1'b0, start};
    end
    count = {1'b0, pos_q} + 9'd1;

    res_o               = '0;
    res_o.status        = StAudio;
    res_o.audio_valid   = audio_v;
    res_o.audio_byte    = audio_v ? b : '0;
    if (item_i.last_byte) begin
      res_o.summary_valid = 1'b1;
      res_o.msg_type      = type_d;
      res_o.type_flags    = flags_d;
      res_o.serialization = sc_d[7:4];
      res_o.compression   = sc_d[3:0];
      if (count < {2'b00, need}) begin
        res_o.status = StTrunc;
      end else if (type_d == TypeAudio) begin
        res_o.status = StAudio;
        if (flags_d != 4'd0) begin
          res_o.sequence_res = first_d;
          res_o.size_word    = second_d;
          res_o.stream_done  = first_d[WordW-1];
        end
      end else if (type_d == TypeError) begin
        res_o.status      = StError;
        res_o.error_code  = first_d;
        res_o.size_word   = second_d;
        res_o.stream_done = 1'b1;
      end else if (type_d == TypeFrontend) begin
        res_o.status    = StFrontend;
        res_o.size_word = first_d;
      end else begin
        res_o.status      = StUnknown;
        res_o.stream_done = 1'b1;
      end
    end

    // restart on the last byte, hold at the top on long messages
    if (item_i.last_byte) begin
      pos_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + 8'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  assign produce_o = audio_v || item_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hw_q     <= '0;
      type_q   <= '0;
      flags_q  <= '0;
      sc_q     <= '0;
      first_q  <= '0;
      second_q <= '0;
    end else if (fire_i) begin
      pos_q    <= pos_d;
      hw_q     <= hw_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
      sc_q     <= sc_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/brd_out_stage.sv */
`default_nettype none

module brd_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire brd_pkg::res_t res_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output brd_pkg::res_t      res_o
);
  import brd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* hw/rtl/binary_response_deframer.sv */
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tlast: last_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result fields; tuser: valid flags
//
// One item per cycle sustained unless a result meets a stalled output; a byte
// passes the input register, then parse logic into the result register.
// A byte gives a result only when it is forwarded audio or the last byte.
// Reset clears the byte position and captured header fields.
// A stalled result holds the parse stage only when that stage has a result to
// hand over; bytes with no result keep flowing.

module binary_response_deframer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire logic          s_axis_tlast,   // last_byte
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [7:0] audio_byte, [11:8] msg_type, [15:12] type_flags, [19:16] serialization,
  // [23:20] compression, [55:24] sequence_res, [87:56] size_word,
  // [119:88] error_code, [120] stream_done, [123:121] status, [127:124] zero
  output logic [127:0]       m_axis_tdata,
  output logic [1:0]         m_axis_tuser    // [0] audio_valid, [1] summary_valid
);
  import brd_pkg::*;

  item_t in_item;
  item_t stage_item;
  logic  stage_valid;
  logic  produce;
  logic  advance;
  res_t  step_res;
  res_t  out_res;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last_byte = s_axis_tlast;

  brd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  brd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (stage_item),
    .fire_i    (advance),
    .produce_o (produce),
    .res_o     (step_res)
  );

  // move on unless a result would land on a full, stalled output register
  assign advance = stage_valid && (!produce || !m_axis_tvalid || m_axis_tready);

  brd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && produce),
    .res_i       (step_res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (out_res)
  );

  assign m_axis_tuser = {out_res.summary_valid, out_res.audio_valid};
  assign m_axis_tdata = {4'b0000, out_res.status, out_res.stream_done,
                         out_res.error_code, out_res.size_word, out_res.sequence_res,
                         out_res.compression, out_res.serialization,
                         out_res.type_flags, out_res.msg_type, out_res.audio_byte};

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'b00))
    else $error("result item with neither audio nor summary");

  a_trunc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.summary_valid && out_res.status == StTrunc) |->
      (!out_res.stream_done && out_res.sequence_res == '0 &&
       out_res.size_word == '0 && out_res.error_code == '0))
    else $error("truncated summary carries words or done");

  a_no_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_res.summary_valid) |-> (m_axis_tdata[127:8] == '0))
    else $error("summary fields set on an audio-only item");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && produce && m_axis_tvalid && !m_axis_tready) |=> stage_valid)
    else $error("parse stage dropped an item while output stalled");

endmodule

`default_nettype wire

/* sim/tb_binary_response_deframer.sv */
`timescale 1ns / 1ps

import brd_pkg::*;

// Expected results of the deframer, kept in step with the accepted bytes.
class deframe_scoreboard;
  res_t        pending_results[$];
  logic [7:0]  position;
  logic [3:0]  hdr_words;
  logic [3:0]  msg_kind;
  logic [3:0]  flags;
  logic [7:0]  ser_comp;
  logic [31:0] word_a;
  logic [31:0] word_b;
  int unsigned mismatches;
  int unsigned audio_seen;
  int unsigned summaries_seen;
  int unsigned truncated_seen;
  int unsigned results_checked;

  function new();
    position        = '0;
    hdr_words       = '0;
    msg_kind        = '0;
    flags           = '0;
    ser_comp        = '0;
    word_a          = '0;
    word_b          = '0;
    mismatches      = 0;
    audio_seen      = 0;
    summaries_seen  = 0;
    truncated_seen  = 0;
    results_checked = 0;
  endfunction

  // Advance the parse state by one accepted byte; queue the result it causes.
  function void note_byte(logic [7:0] b, logic last);
    res_t        r;
    int unsigned p;
    int unsigned start;
    int unsigned q;
    int unsigned need;
    bit          has_words;
    bit          fwd;
    bit          done;
    r    = '0;
    fwd  = 1'b0;
    done = 1'b0;
    p    = 32'(position);
    if (p == 0) begin
      hdr_words = (b[3:0] == 4'd0) ? 4'd1 : b[3:0];
      msg_kind  = '0;
      flags     = '0;
      ser_comp  = '0;
      word_a    = '0;
      word_b    = '0;
    end else if (p == 1) begin
      msg_kind = b[7:4];
      flags    = b[3:0];
    end else if (p == 2) begin
      ser_comp = b;
    end

    start     = 4 * 32'(hdr_words);
    has_words = (msg_kind == TypeAudio && flags != 4'd0) || msg_kind == TypeError ||
                msg_kind == TypeFrontend;
    if (p >= 2 && p >= start) begin
      q = p - start;
      if (has_words && q < 4) begin
        word_a = {word_a[23:0], b};
      end else if (has_words && q < 8 && msg_kind != TypeFrontend) begin
        word_b = {word_b[23:0], b};
      end else if (msg_kind == TypeAudio && flags != 4'd0 && q >= 8) begin
        fwd = 1'b1;
      end
    end

    if (fwd) begin
      r.audio_valid = 1'b1;
      r.audio_byte  = b;
      audio_seen++;
    end

    if (last) begin
      need = start;
      if ((msg_kind == TypeAudio && flags != 4'd0) || msg_kind == TypeError) begin
        need = start + 8;
      end else if (msg_kind == TypeFrontend) begin
        need = start + 4;
      end
      r.summary_valid = 1'b1;
      r.msg_type      = msg_kind;
      r.type_flags    = flags;
      r.serialization = ser_comp[7:4];
      r.compression   = ser_comp[3:0];
      if (p + 1 < need) begin
        r.status = StTrunc;
        truncated_seen++;
      end else if (msg_kind == TypeAudio) begin
        r.status = StAudio;
        if (flags != 4'd0) begin
          r.sequence_res = word_a;
          r.size_word    = word_b;
          done           = word_a[31];
        end
      end else if (msg_kind == TypeError) begin
        r.status     = StError;
        r.error_code = word_a;
        r.size_word  = word_b;
        done         = 1'b1;
      end else if (msg_kind == TypeFrontend) begin
        r.status    = StFrontend;
        r.size_word = word_a;
      end else begin
        r.status = StUnknown;
        done     = 1'b1;
      end
      r.stream_done = done;
      summaries_seen++;
      position = '0;
    end else if (position != PosMax) begin
      position = position + 8'd1;
    end

    if (fwd || last) pending_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s: expected %h, got %h (result %0d)",
                 name, want, got, results_checked);
      end
    end
  endfunction

  // Compare one accepted result against the oldest expectation.
  function void check_result(logic [127:0] tdata, logic [1:0] tuser);
    res_t e;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: tuser %b tdata %h", tuser, tdata);
      end
      return;
    end
    e = pending_results.pop_front();
    compare_field("audio_valid", 32'(e.audio_valid), 32'(tuser[0]));
    compare_field("summary_valid", 32'(e.summary_valid), 32'(tuser[1]));
    compare_field("audio_byte", 32'(e.audio_byte), 32'(tdata[7:0]));
    compare_field("msg_type", 32'(e.msg_type), 32'(tdata[11:8]));
    compare_field("type_flags", 32'(e.type_flags), 32'(tdata[15:12]));
    compare_field("serialization", 32'(e.serialization), 32'(tdata[19:16]));
    compare_field("compression", 32'(e.compression), 32'(tdata[23:20]));
    compare_field("sequence_res", e.sequence_res, tdata[55:24]);
    compare_field("size_word", e.size_word, tdata[87:56]);
    compare_field("error_code", e.error_code, tdata[119:88]);
    compare_field("stream_done", 32'(e.stream_done), 32'(tdata[120]));
    compare_field("status", 32'(e.status), 32'(tdata[123:121]));
    compare_field("pad", 32'd0, 32'(tdata[127:124]));
    results_checked++;
  endfunction

  function int unsigned failures();
    return mismatches + pending_results.size();
  endfunction
endclass

module tb_binary_response_deframer;

  localparam int unsigned ByteTarget = 850;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CalmStart = 600;
  localparam int unsigned CalmEnd = 1000;
  localparam int unsigned IdlePct = 34;

  typedef logic [7:0] frame_q_t[$];

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  int unsigned  cycle_count = 0;
  int unsigned  sent_bytes = 0;
  int unsigned  frames_sent = 0;
  bit           hold_request = 1'b0;

  deframe_scoreboard deframe_sb = new();

  binary_response_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit take_gap();
    if (cycle_count >= CalmStart && cycle_count < CalmEnd) return 1'b0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      deframe_sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int unsigned k;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        for (k = 0; k < HoldCycles; k++) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_axis_tready <= !take_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (take_gap()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    deframe_sb.note_byte(b, last);
    sent_bytes++;
  endtask

  task automatic send_frame(input frame_q_t frame);
    int unsigned k;
    for (k = 0; k < frame.size(); k++) begin
      send_byte(frame[k], k == frame.size() - 1);
    end
    frames_sent++;
  endtask

  // Build a mostly well-formed message with random content; some are cut short
  // or are plain noise.
  task automatic send_random_frame(input bit long_audio);
    frame_q_t    frame;
    int unsigned pick;
    int unsigned k;
    int unsigned words;
    int unsigned tail;
    logic [3:0]  hw_nib;
    logic [3:0]  kind;
    logic [3:0]  flg;
    pick = long_audio ? 0 : $urandom_range(0, 99);
    if (pick >= 90) begin
      tail = $urandom_range(1, 10);
      for (k = 0; k < tail; k++) frame.push_back(8'($urandom));
      send_frame(frame);
      return;
    end
    if (pick < 35) kind = TypeAudio;
    else if (pick < 55) kind = TypeError;
    else if (pick < 70) kind = TypeFrontend;
    else kind = 4'($urandom);
    if (kind == TypeAudio) flg = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
    else flg = 4'($urandom);
    if ($urandom_range(0, 99) < 15) hw_nib = 4'($urandom);
    else hw_nib = 4'($urandom_range(0, 1));
    if (long_audio) begin
      kind = TypeAudio;
      flg  = 4'd1;
    end

    frame.push_back({4'($urandom), hw_nib});
    frame.push_back({kind, flg});
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    words = (hw_nib == 4'd0) ? 1 : 32'(hw_nib);
    for (k = 4; k < 4 * words; k++) frame.push_back(8'($urandom));

    if ((kind == TypeAudio && flg != 4'd0) || kind == TypeError) tail = 8;
    else if (kind == TypeFrontend) tail = 4;
    else tail = 0;
    for (k = 0; k < tail; k++) frame.push_back(8'($urandom));

    if (long_audio) tail = 280;
    else if (kind == TypeAudio && flg != 4'd0) tail = $urandom_range(0, 12);
    else tail = $urandom_range(0, 3);
    for (k = 0; k < tail; k++) frame.push_back(8'($urandom));

    if (!long_audio && $urandom_range(0, 99) < 15) begin
      tail = $urandom_range(1, frame.size());
      while (frame.size() > tail) void'(frame.pop_back());
    end
    send_frame(frame);
  endtask

  initial begin : stimulus
    frame_q_t frame;
    bit       long_done;
    long_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single byte with header size zero: cut short inside the header
    frame = '{8'h10};
    send_frame(frame);
    // complete frontend message
    frame = '{8'h01, 8'hC5, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01};
    send_frame(frame);
    // audio with a negative sequence ends the stream; one audio byte on the last
    frame = '{8'hF1, 8'hB1, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'h00, 8'h00, 8'h00, 8'h00, 8'hAA};
    send_frame(frame);
    // unknown type with the header complete
    frame = '{8'h01, 8'h3F, 8'h12, 8'h00};
    send_frame(frame);

    while (sent_bytes < ByteTarget) begin
      if (!long_done && sent_bytes >= 350) begin
        hold_request = 1'b1;
        send_random_frame(1'b1);
        long_done = 1'b1;
      end else begin
        send_random_frame(1'b0);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (deframe_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages over %0d cycles.",
             sent_bytes, frames_sent, cycle_count);
    $display("Checked %0d results: %0d audio bytes, %0d summaries, %0d truncated.",
             deframe_sb.results_checked, deframe_sb.audio_seen,
             deframe_sb.summaries_seen, deframe_sb.truncated_seen);
    if (deframe_sb.failures() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/brd_pkg.sv
hw/rtl/brd_in_stage.sv
hw/rtl/brd_parse.sv
hw/rtl/brd_out_stage.sv
hw/rtl/binary_response_deframer.sv
sim/tb_binary_response_deframer.sv
